// ----- src/bstk_pkg.sv -----
// Shared constants, codes and command/status types for the bounded stack.
package bstk_pkg;

    localparam int DEPTH   = 8;
    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK     = 3'd3;
    localparam logic [OP_W-1:0] OP_SMALLEST = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;

    typedef enum logic [2:0] {
        E_NONE,
        E_PUSH_OK,
        E_OVERFLOW,
        E_EMPTY,
        E_READ,
        E_TRAV,
        E_MIN
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  wr;
        logic  dec_count;
        logic  rd_top;
        logic  rd_first;
        logic  rd_down;
        logic  rd_up;
        logic  min_upd;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic op_push;
        logic op_pop;
        logic op_trav;
        logic op_peek;
        logic op_min;
        logic empty;
        logic full;
        logic ptr_zero;
        logic ptr_top;
    } t_stat;

endpackage

// ----- src/bstk_ctrl.sv -----
// Controller state machine sequencing each stack operation.
module bstk_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bstk_pkg::t_stat i_stat,
    output bstk_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_READ   = 5'b00100,
        S_TRAV   = 5'b01000,
        S_SCAN   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit = bstk_pkg::E_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_stat.op_push) begin
                    if (i_stat.full) begin
                        o_cmd.emit = bstk_pkg::E_OVERFLOW;
                    end else begin
                        o_cmd.wr   = 1'b1;
                        o_cmd.emit = bstk_pkg::E_PUSH_OK;
                    end
                end else if (i_stat.op_pop || i_stat.op_trav || i_stat.op_peek
                             || i_stat.op_min) begin
                    if (i_stat.empty) begin
                        o_cmd.emit = bstk_pkg::E_EMPTY;
                    end else if (i_stat.op_pop) begin
                        o_cmd.rd_top    = 1'b1;
                        o_cmd.dec_count = 1'b1;
                        n_state         = S_READ;
                    end else if (i_stat.op_peek) begin
                        o_cmd.rd_top = 1'b1;
                        n_state      = S_READ;
                    end else if (i_stat.op_trav) begin
                        o_cmd.rd_top = 1'b1;
                        n_state      = S_TRAV;
                    end else begin
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_READ: begin
                o_cmd.emit = bstk_pkg::E_READ;
                n_state    = S_IDLE;
            end
            S_TRAV: begin
                o_cmd.emit = bstk_pkg::E_TRAV;
                if (i_stat.ptr_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_down = 1'b1;
                end
            end
            S_SCAN: begin
                o_cmd.min_upd = 1'b1;
                if (i_stat.ptr_top) begin
                    o_cmd.emit = bstk_pkg::E_MIN;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_up = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- src/bstk_dpath.sv -----
// Datapath: entry memory, fill count, scan pointer, running minimum and result register.
module bstk_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bstk_pkg::OP_W-1:0]           i_operation,
    input  logic signed [bstk_pkg::WORD_W-1:0]  i_push_value,
    input  bstk_pkg::t_cmd                      i_cmd,
    output bstk_pkg::t_stat                     o_stat,
    output logic                                o_valid,
    output logic [bstk_pkg::STAT_W-1:0]         o_status,
    output logic signed [bstk_pkg::WORD_W-1:0]  o_data_value,
    output logic                                o_last
);

    logic signed [bstk_pkg::WORD_W-1:0] r_mem [bstk_pkg::DEPTH];
    logic signed [bstk_pkg::WORD_W-1:0] r_rdata;
    logic signed [bstk_pkg::WORD_W-1:0] r_val;
    logic signed [bstk_pkg::WORD_W-1:0] r_min;
    logic signed [bstk_pkg::WORD_W-1:0] n_min;
    logic [bstk_pkg::OP_W-1:0]          r_op;
    logic [bstk_pkg::COUNT_W-1:0]       r_count;
    logic [bstk_pkg::COUNT_W-1:0]       n_count;
    logic [bstk_pkg::COUNT_W-1:0]       w_top;
    logic [bstk_pkg::ADDR_W-1:0]        w_top_addr;
    logic [bstk_pkg::ADDR_W-1:0]        r_ptr;
    logic [bstk_pkg::ADDR_W-1:0]        w_rd_addr;
    logic                               w_rd_en;
    logic                               r_valid;
    logic                               n_valid;
    logic [bstk_pkg::STAT_W-1:0]        r_status;
    logic [bstk_pkg::STAT_W-1:0]        n_status;
    logic signed [bstk_pkg::WORD_W-1:0] r_data;
    logic signed [bstk_pkg::WORD_W-1:0] n_data;
    logic                               r_last;
    logic                               n_last;

    assign w_top      = r_count - bstk_pkg::COUNT_W'(1);
    assign w_top_addr = w_top[bstk_pkg::ADDR_W-1:0];

    assign o_stat.op_push  = (r_op == bstk_pkg::OP_PUSH);
    assign o_stat.op_pop   = (r_op == bstk_pkg::OP_POP);
    assign o_stat.op_trav  = (r_op == bstk_pkg::OP_TRAVERSE);
    assign o_stat.op_peek  = (r_op == bstk_pkg::OP_PEEK);
    assign o_stat.op_min   = (r_op == bstk_pkg::OP_SMALLEST);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == bstk_pkg::COUNT_W'(bstk_pkg::DEPTH));
    assign o_stat.ptr_zero = (r_ptr == '0);
    assign o_stat.ptr_top  = (r_ptr == w_top_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_val <= i_push_value;
        end
    end

    always_comb begin
        w_rd_en   = i_cmd.rd_top | i_cmd.rd_first | i_cmd.rd_down | i_cmd.rd_up;
        w_rd_addr = r_ptr;
        if (i_cmd.rd_top) begin
            w_rd_addr = w_top_addr;
        end else if (i_cmd.rd_first) begin
            w_rd_addr = '0;
        end else if (i_cmd.rd_down) begin
            w_rd_addr = r_ptr - bstk_pkg::ADDR_W'(1);
        end else if (i_cmd.rd_up) begin
            w_rd_addr = r_ptr + bstk_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_count[bstk_pkg::ADDR_W-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
            r_ptr   <= w_rd_addr;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.wr) begin
            n_count = r_count + bstk_pkg::COUNT_W'(1);
        end else if (i_cmd.dec_count) begin
            n_count = w_top;
        end
    end

    always_comb begin
        n_min = r_min;
        if ((r_ptr == '0) || (r_rdata < r_min)) begin
            n_min = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.min_upd) begin
            r_min <= n_min;
        end
    end

    always_comb begin
        n_valid  = 1'b1;
        n_status = bstk_pkg::ST_OK;
        n_data   = '0;
        n_last   = 1'b1;
        case (i_cmd.emit)
            bstk_pkg::E_NONE: begin
                n_valid = 1'b0;
            end
            bstk_pkg::E_PUSH_OK: begin
                n_status = bstk_pkg::ST_OK;
            end
            bstk_pkg::E_OVERFLOW: begin
                n_status = bstk_pkg::ST_OVERFLOW;
            end
            bstk_pkg::E_EMPTY: begin
                n_status = bstk_pkg::ST_EMPTY;
            end
            bstk_pkg::E_READ: begin
                n_data = r_rdata;
            end
            bstk_pkg::E_TRAV: begin
                n_data = r_rdata;
                n_last = (r_ptr == '0);
            end
            bstk_pkg::E_MIN: begin
                n_data = n_min;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_data_value = r_data;
    assign o_last       = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bstk_pkg::COUNT_W'(bstk_pkg::DEPTH))
        else $error("fill count above depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> !o_stat.full)
        else $error("write into full stack");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dec_count |=> (r_count == $past(w_top)))
        else $error("pop did not drop the fill count by one");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_down |-> (r_ptr != '0))
        else $error("traverse walked below the bottom entry");

    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != bstk_pkg::E_NONE) |=> r_valid)
        else $error("result lost before the output register");

endmodule

// ----- src/bounded_stack_with_min_scan.sv -----
// Top level of the bounded stack with traverse and minimum scan.
//
// Usage: drive i_operation and i_push_value and raise start; the command
// transfers at a rising edge with start high and busy low. busy stays high
// until the operation has issued its last result, so the next command can
// transfer in the cycle after that.
// Results appear on o_status, o_data_value and o_last, marked by o_valid for
// exactly one cycle each; o_last flags the final result of a command. The
// receiver cannot stall, so every result must be taken when it is shown.
// Sequence per command, with N the fill count: push, empty and overflow cases
// give their one result from the decode state; pop and peek read the top
// entry and give it from the read state; traverse gives N results, top to
// bottom, on consecutive cycles; smallest walks all N entries from the bottom
// and gives one result. The entry memory's one registered read port sets the
// walk to one entry per cycle. Unknown operation codes give no result.
// Reset empties the stack and clears busy and o_valid; the entry memory is
// not cleared, as only stored entries are ever read.
module bounded_stack_with_min_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bstk_pkg::OP_W-1:0]           i_operation,
    input  logic signed [bstk_pkg::WORD_W-1:0]  i_push_value,
    output logic                                o_valid,
    output logic [bstk_pkg::STAT_W-1:0]         o_status,
    output logic signed [bstk_pkg::WORD_W-1:0]  o_data_value,
    output logic                                o_last
);

    bstk_pkg::t_cmd  w_cmd;
    bstk_pkg::t_stat w_stat;

    bstk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    bstk_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_data_value (o_data_value),
        .o_last       (o_last)
    );

endmodule

// ----- tb/stack_result_checker.sv -----
// Result checker for the bounded stack: mirrors the stack, predicts and compares results.
`timescale 1ns / 100ps

module stack_result_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [bstk_pkg::OP_W-1:0]           i_operation,
    input  logic signed [bstk_pkg::WORD_W-1:0]  i_push_value,
    input  logic                                o_valid,
    input  logic [bstk_pkg::STAT_W-1:0]         o_status,
    input  logic signed [bstk_pkg::WORD_W-1:0]  o_data_value,
    input  logic                                o_last,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic [bstk_pkg::STAT_W-1:0]         status;
        logic signed [bstk_pkg::WORD_W-1:0]  data_value;
        logic                                last;
    } t_stack_result;

    t_stack_result                       expected_results[$];
    logic signed [bstk_pkg::WORD_W-1:0]  stack_words[bstk_pkg::DEPTH];
    int                                  stack_fill;

    task automatic queue_result(input logic [bstk_pkg::STAT_W-1:0] status,
                                input logic signed [bstk_pkg::WORD_W-1:0] data_value,
                                input logic last);
        t_stack_result r;
        r.status     = status;
        r.data_value = data_value;
        r.last       = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_command(input logic [bstk_pkg::OP_W-1:0] op,
                                   input logic signed [bstk_pkg::WORD_W-1:0] value);
        logic signed [bstk_pkg::WORD_W-1:0] lowest;
        if (op == bstk_pkg::OP_PUSH) begin
            if (stack_fill >= bstk_pkg::DEPTH) begin
                queue_result(bstk_pkg::ST_OVERFLOW, '0, 1'b1);
            end else begin
                stack_words[stack_fill] = value;
                stack_fill++;
                queue_result(bstk_pkg::ST_OK, '0, 1'b1);
            end
        end else if (op == bstk_pkg::OP_POP || op == bstk_pkg::OP_TRAVERSE
                     || op == bstk_pkg::OP_PEEK || op == bstk_pkg::OP_SMALLEST) begin
            if (stack_fill == 0) begin
                queue_result(bstk_pkg::ST_EMPTY, '0, 1'b1);
            end else begin
                case (op)
                    bstk_pkg::OP_POP: begin
                        stack_fill--;
                        queue_result(bstk_pkg::ST_OK, stack_words[stack_fill], 1'b1);
                    end
                    bstk_pkg::OP_TRAVERSE: begin
                        for (int i = stack_fill - 1; i >= 0; i--)
                            queue_result(bstk_pkg::ST_OK, stack_words[i], i == 0);
                    end
                    bstk_pkg::OP_PEEK: begin
                        queue_result(bstk_pkg::ST_OK, stack_words[stack_fill - 1], 1'b1);
                    end
                    default: begin
                        lowest = stack_words[0];
                        for (int i = 1; i < stack_fill; i++)
                            if (stack_words[i] < lowest)
                                lowest = stack_words[i];
                        queue_result(bstk_pkg::ST_OK, lowest, 1'b1);
                    end
                endcase
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_result exp_r;
        if (!i_rst_n) begin
            stack_fill = 0;
            expected_results.delete();
        end else begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d data_value %0d last %0d",
                           o_status, o_data_value, o_last);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                        fail_count++;
                    end
                    if (o_data_value !== exp_r.data_value) begin
                        $error("data_value: expected %0d, actual %0d",
                               exp_r.data_value, o_data_value);
                        fail_count++;
                    end
                    if (o_last !== exp_r.last) begin
                        $error("last: expected %0d, actual %0d", exp_r.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_command(i_operation, i_push_value);
        end
        pending <= expected_results.size();
    end

endmodule

// ----- tb/tb_bounded_stack_with_min_scan.sv -----
// Testbench top for the bounded stack: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb_bounded_stack_with_min_scan;

    localparam logic [bstk_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [bstk_pkg::OP_W-1:0] OP_RSVD_MID   = 3'd6;
    localparam logic [bstk_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DRAIN_CYCLES    = 20;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [bstk_pkg::OP_W-1:0]           i_operation = bstk_pkg::OP_PUSH;
    logic signed [bstk_pkg::WORD_W-1:0]  i_push_value = '0;
    logic                                o_valid;
    logic [bstk_pkg::STAT_W-1:0]         o_status;
    logic signed [bstk_pkg::WORD_W-1:0]  o_data_value;
    logic                                o_last;
    int                                  fail_count;
    int                                  pending;
    int                                  idle_cycles = 0;
    int                                  phase_idle_pct[4] = '{0, 64, 0, 36};

    always #5 i_clk = ~i_clk;

    bounded_stack_with_min_scan dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_data_value (o_data_value),
        .o_last       (o_last)
    );

    stack_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_data_value (o_data_value),
        .o_last       (o_last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bounded_stack_with_min_scan: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [bstk_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0: random_word = 32'sh8000_0000;
            1: random_word = 32'sh7fff_ffff;
            2: random_word = $urandom_range(3) - 1;
            default: random_word = $urandom;
        endcase
    endfunction

    function automatic logic [bstk_pkg::OP_W-1:0] random_operation();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            random_operation = bstk_pkg::OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        else if (roll < 42)
            random_operation = bstk_pkg::OP_PUSH;
        else if (roll < 66)
            random_operation = bstk_pkg::OP_POP;
        else if (roll < 78)
            random_operation = bstk_pkg::OP_TRAVERSE;
        else if (roll < 88)
            random_operation = bstk_pkg::OP_PEEK;
        else
            random_operation = bstk_pkg::OP_SMALLEST;
    endfunction

    task automatic send(input logic [bstk_pkg::OP_W-1:0] op,
                        input logic signed [bstk_pkg::WORD_W-1:0] value,
                        input int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(bstk_pkg::OP_POP, random_word(), 0);
        send(bstk_pkg::OP_PEEK, random_word(), 0);
        send(bstk_pkg::OP_TRAVERSE, random_word(), 0);
        send(bstk_pkg::OP_SMALLEST, random_word(), 0);
        send(bstk_pkg::OP_PUSH, 32'sh7fff_ffff, 0);
        send(bstk_pkg::OP_PUSH, 32'sh8000_0000, 0);
        send(bstk_pkg::OP_PUSH, '0, 0);
        send(bstk_pkg::OP_PUSH, -32'sd1, 0);
        repeat (bstk_pkg::DEPTH - 4) send(bstk_pkg::OP_PUSH, random_word(), 0);
        send(bstk_pkg::OP_PUSH, random_word(), 0);
        send(bstk_pkg::OP_TRAVERSE, random_word(), 0);
        send(bstk_pkg::OP_SMALLEST, random_word(), 0);
        send(bstk_pkg::OP_PEEK, random_word(), 0);
        send(OP_RSVD_FIRST, random_word(), 0);
        send(OP_RSVD_MID, random_word(), 0);
        send(OP_RSVD_LAST, random_word(), 0);
        send(bstk_pkg::OP_POP, random_word(), 0);
        send(bstk_pkg::OP_TRAVERSE, random_word(), 0);
        send(bstk_pkg::OP_SMALLEST, random_word(), 0);

        foreach (phase_idle_pct[p])
            repeat (ITEMS_PER_PHASE)
                send(random_operation(), random_word(), phase_idle_pct[p]);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_bounded_stack_with_min_scan: clean");
        else
            $display("tb_bounded_stack_with_min_scan: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bstk_pkg.sv
src/bstk_ctrl.sv
src/bstk_dpath.sv
src/bounded_stack_with_min_scan.sv
tb/stack_result_checker.sv
tb/tb_bounded_stack_with_min_scan.sv
